/* rtl/tklc_pkg.sv */
`default_nettype none

package tklc_pkg;

  // width of a chain length and its saturation value
  localparam int unsigned LenW = 7;
  localparam logic [LenW-1:0] LenMax = '1;

  // width of each key
  localparam int unsigned KeyW = 32;

  // request travelling down the row of cells
  typedef struct packed {
    logic                   vld;
    logic                   placed;
    logic signed [KeyW-1:0] height;
    logic signed [KeyW-1:0] score;
    logic [LenW-1:0]        len;
  } token_t;

endpackage

`default_nettype wire

/* rtl/tklc_cell.sv */
`default_nettype none

module tklc_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire tklc_pkg::token_t tok_i,
  output tklc_pkg::token_t     tok_o
);

  logic                             valid_q;
  logic signed [tklc_pkg::KeyW-1:0] height_q;
  logic signed [tklc_pkg::KeyW-1:0] score_q;
  logic [tklc_pkg::LenW-1:0]        len_q;
  tklc_pkg::token_t                 tok_q, tok_d;
  logic                             store_en;
  logic [tklc_pkg::LenW-1:0]        len_new;

  // compare against the held item, or take the request into an empty cell
  always_comb begin
    tok_d    = tok_i;
    store_en = 1'b0;
    len_new  = (tok_i.len >= tklc_pkg::LenMax) ? tklc_pkg::LenMax
                                                : tok_i.len + tklc_pkg::LenW'(1);
    if (tok_i.vld && !tok_i.placed) begin
      if (valid_q) begin
        if ((height_q < tok_i.height) && (score_q > tok_i.score) &&
            (len_q > tok_i.len)) begin
          tok_d.len = len_q;
        end
      end else begin
        store_en     = 1'b1;
        tok_d.placed = 1'b1;
        tok_d.len    = len_new;
      end
    end
  end

  // occupancy flag, cleared at the end of a set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (store_en) begin
      valid_q <= 1'b1;
    end
  end

  // held item
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      height_q <= tok_i.height;
      score_q  <= tok_i.score;
      len_q    <= len_new;
    end
  end

  // hand the request on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* rtl/two_key_longest_chain.sv */
// each stored item travels down a row of MAX_ITEMS cells, one cell a cycle,
// so busy stays high from when the item is taken until its request leaves
// the row; no new item is taken while busy is high
// an item beyond capacity is taken without raising busy
// the result strobe is registered and comes in the cycle after the last item finishes; no stall
// reset clears the set count, best length, overflow flag and all cell flags
`default_nettype none

module two_key_longest_chain #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [tklc_pkg::KeyW-1:0] height_i,
  input  wire logic signed [tklc_pkg::KeyW-1:0] score_i,
  input  wire logic                             last_item_i,
  output logic                                  result_valid_o,
  output logic [tklc_pkg::LenW-1:0]             chain_length_o,
  output logic                                  overflowed_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  tklc_pkg::token_t          tok [0:MAX_ITEMS];
  tklc_pkg::token_t          inject_q, inject_d;
  logic                      busy_q, busy_d;
  logic                      last_q, last_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [tklc_pkg::LenW-1:0] best_q, best_d, best_new;
  logic                      ovf_q, ovf_d;
  logic                      res_vld_d, res_ovf_d;
  logic [tklc_pkg::LenW-1:0] res_len_d;
  logic                      clear;
  logic                      accept;

  assign accept = start && !busy_q;
  assign tok[0] = inject_q;

  // row of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    tklc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clear_i(clear),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  // set bookkeeping and result
  always_comb begin
    inject_d  = '0;
    busy_d    = busy_q;
    last_d    = last_q;
    count_d   = count_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    res_vld_d = 1'b0;
    res_len_d = best_q;
    res_ovf_d = ovf_q;
    clear     = 1'b0;
    best_new  = (tok[MAX_ITEMS].len > best_q) ? tok[MAX_ITEMS].len : best_q;

    if (accept) begin
      if (count_q < CntW'(MAX_ITEMS)) begin
        inject_d.vld    = 1'b1;
        inject_d.height = height_i;
        inject_d.score  = score_i;
        busy_d          = 1'b1;
        last_d          = last_item_i;
        count_d         = count_q + CntW'(1);
      end else begin
        // no room left: drop the item, note it
        ovf_d = 1'b1;
        if (last_item_i) begin
          res_vld_d = 1'b1;
          res_len_d = best_q;
          res_ovf_d = 1'b1;
          clear     = 1'b1;
        end
      end
    end

    // request has passed the whole row
    if (tok[MAX_ITEMS].vld) begin
      busy_d = 1'b0;
      best_d = best_new;
      if (last_q) begin
        res_vld_d = 1'b1;
        res_len_d = best_new;
        res_ovf_d = ovf_q;
        clear     = 1'b1;
      end
    end

    if (clear) begin
      count_d = '0;
      best_d  = '0;
      ovf_d   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inject_q       <= '0;
      busy_q         <= 1'b0;
      last_q         <= 1'b0;
      count_q        <= '0;
      best_q         <= '0;
      ovf_q          <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      inject_q       <= inject_d;
      busy_q         <= busy_d;
      last_q         <= last_d;
      count_q        <= count_d;
      best_q         <= best_d;
      ovf_q          <= ovf_d;
      result_valid_o <= res_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_vld_d) begin
      chain_length_o <= res_len_d;
      overflowed_o   <= res_ovf_d;
    end
  end

  assign busy = busy_q;

endmodule

`default_nettype wire
